[design/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg: shared definitions for the load/store pair unit
// Instruction field positions, mode and status codes, lane control types.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // default size of the local byte memory
  localparam int unsigned MEM_BYTES_DEFAULT = 4096;

  // one byte lane per byte of a 64-bit word
  localparam int unsigned LANES = 8;
  localparam int unsigned LANE_BITS = 3;

  // instruction word fields
  localparam int unsigned IR_OPC_LSB  = 30;  // 0xc0000000
  localparam int unsigned IR_MODE_LSB = 23;  // 0x01800000
  localparam int unsigned IR_LOAD_BIT = 22;  // 0x00400000
  localparam int unsigned IR_IMM_LSB  = 15;  // 0x003f8000
  localparam int unsigned IR_RT2_LSB  = 10;  // 0x00007c00
  localparam int unsigned IR_RN_LSB   = 5;   // 0x000003e0
  localparam int unsigned IR_RT_LSB   = 0;   // 0x0000001f

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_POST   = 2'd1,
    MODE_OFFSET = 2'd2,
    MODE_PRE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_UNSUP = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // request shared by all byte lanes
  typedef struct packed {
    logic en;
    logic we;
    logic wide;
  } lane_req_t;

  // describes the word whose bytes come back from the lanes
  typedef struct packed {
    logic                 wide;
    logic [LANE_BITS-1:0] off;
  } merge_ctl_t;

endpackage

[design/lsp_lane.sv]
// ----------------------------------------------------------------------------
// lsp_lane: one byte lane of the banked data memory
// Holds every byte whose address is LANE modulo 8 and picks its own byte
// of a big-endian word that starts at any byte address.
// ----------------------------------------------------------------------------
module lsp_lane #(
  parameter int unsigned MEM_BYTES = lsp_pkg::MEM_BYTES_DEFAULT,
  parameter int unsigned LANE      = 0
) (
  input  logic                      clk_i,
  input  lsp_pkg::lane_req_t        req_i,
  input  logic [$clog2(MEM_BYTES)-1:0] addr_i,
  input  logic [63:0]               wdata_i,
  output logic [7:0]                rdata_o
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned ROWS = (MEM_BYTES + lsp_pkg::LANES - 1) / lsp_pkg::LANES;
  localparam int unsigned RW   = AW - lsp_pkg::LANE_BITS;
  localparam logic [lsp_pkg::LANE_BITS-1:0] LaneId = lsp_pkg::LANE_BITS'(LANE);

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  logic [lsp_pkg::LANE_BITS-1:0] pos;     // byte position within the word
  logic [lsp_pkg::LANE_BITS-1:0] sel;     // byte index counted from the LSB
  logic                          active;
  logic [RW-1:0]                 row;
  logic [7:0]                    wbyte;

  // which byte of the word lands here, and in which row
  always_comb begin
    pos    = LaneId - addr_i[lsp_pkg::LANE_BITS-1:0];
    active = req_i.wide | ~pos[lsp_pkg::LANE_BITS-1];
    sel    = (req_i.wide ? 3'd7 : 3'd3) - pos;
    row    = addr_i[AW-1:lsp_pkg::LANE_BITS]
           + RW'(LaneId < addr_i[lsp_pkg::LANE_BITS-1:0]);
    wbyte  = wdata_i[8*sel +: 8];
  end

  // single-port bank, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.en && active) begin
      if (req_i.we) begin
        mem_q[row] <= wbyte;
      end else begin
        rdata_q <= mem_q[row];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/lsp_merge.sv]
// ----------------------------------------------------------------------------
// lsp_merge: byte lane merge
// Rotates the lane bytes back into a big-endian word, zero-extending
// 32-bit words.
// ----------------------------------------------------------------------------
module lsp_merge (
  input  logic [lsp_pkg::LANES-1:0][7:0] lane_data_i,
  input  lsp_pkg::merge_ctl_t            ctl_i,
  output logic [63:0]                    word_o
);

  logic [lsp_pkg::LANE_BITS-1:0] src [lsp_pkg::LANES];

  always_comb begin
    word_o = '0;
    for (int i = 0; i < lsp_pkg::LANES; i++) begin
      src[i] = ctl_i.off + lsp_pkg::LANE_BITS'(i);
      if (ctl_i.wide) begin
        word_o[8*(7-i) +: 8] = lane_data_i[src[i]];
      end else if (i < 4) begin
        word_o[8*(3-i) +: 8] = lane_data_i[src[i]];
      end
    end
  end

endmodule

[design/load_store_pair_unit.sv]
// ----------------------------------------------------------------------------
// load_store_pair_unit: load-pair / store-pair execution unit
// Decodes one pair instruction, checks the access against the local memory
// and moves two big-endian words through eight byte lanes.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  instr, base_value, store_first,
//                                               store_second
//   out       output     out_valid_o/out_ready_i load_first, load_second,
//                                               loads_valid, first_reg,
//                                               second_reg, base_reg, new_base,
//                                               base_written, status
//   cfg       input      cfg_we_i               cfg_wdata_i (memory_base)
//
// From acceptance to a loaded output register an item steps through add,
// relocate, range check, one step per word on the single lane port (S_W0,
// S_W1) and the registered lane read (S_RD). A failing item skips the lane steps.
// One item is in flight; a new item is accepted once the previous result
// sits in the output register, even while that result is stalled.
// Reset clears control state and memory_base; memory contents stay
// undefined until written.
// ----------------------------------------------------------------------------
module load_store_pair_unit #(
  parameter int unsigned MEM_BYTES = lsp_pkg::MEM_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_i,
  input  logic [63:0] base_value_i,
  input  logic [63:0] store_first_i,
  input  logic [63:0] store_second_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] load_first_o,
  output logic [63:0] load_second_o,
  output logic        loads_valid_o,
  output logic [4:0]  first_reg_o,
  output logic [4:0]  second_reg_o,
  output logic [4:0]  base_reg_o,
  output logic [63:0] new_base_o,
  output logic        base_written_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [63:0] Limit32 = 64'(MEM_BYTES - 8);
  localparam logic [63:0] Limit64 = 64'(MEM_BYTES - 16);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_REL   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_W0    = 7'b0001000,
    S_W1    = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] mem_base_q;

  // item registers
  logic [31:0] instr_q;
  logic [63:0] base_q, sum_q, rel_q, st0_q, st1_q, ld0_q, ld1_q;
  lsp_pkg::status_e status_q;

  // decoded fields
  lsp_pkg::mode_e mode_in, mode_q;
  logic           wide_in, wide_q, load_q;
  logic [63:0]    offset_in;

  // lane interface
  lsp_pkg::lane_req_t             lane_req;
  logic [AW-1:0]                  lane_addr;
  logic [63:0]                    lane_wdata;
  logic [lsp_pkg::LANES-1:0][7:0] lane_rdata;
  lsp_pkg::merge_ctl_t            merge_ctl;
  logic [lsp_pkg::LANE_BITS-1:0]  rd_off_q;
  logic [63:0]                    merged;
  logic [AW-1:0]                  addr1;

  // output register
  logic        out_valid_q;
  logic [63:0] out_ld0_q, out_ld1_q, out_nb_q;
  logic        out_lv_q, out_bw_q;
  logic [4:0]  out_rt_q, out_rt2_q, out_rn_q;
  logic [1:0]  out_st_q;
  logic        out_load;

  // decode of the incoming word; offset is sign-extended imm7 scaled by size
  assign mode_in   = lsp_pkg::mode_e'(instr_i[lsp_pkg::IR_MODE_LSB +: 2]);
  assign wide_in   = |instr_i[lsp_pkg::IR_OPC_LSB +: 2];
  assign offset_in = {{57{instr_i[lsp_pkg::IR_IMM_LSB+6]}},
                      instr_i[lsp_pkg::IR_IMM_LSB +: 7]} << (wide_in ? 3 : 2);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign addr1      = rel_q[AW-1:0] + (wide_q ? AW'(8) : AW'(4));

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_base_q <= '0;
    end else if (cfg_we_i) begin
      mem_base_q <= cfg_wdata_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_REL;
      S_REL:   state_d = S_CHECK;
      S_CHECK: begin
        if (mode_q == lsp_pkg::MODE_NONE) begin
          state_d = S_DONE;
        end else if (rel_q > (wide_q ? Limit64 : Limit32)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_W0;
        end
      end
      S_W0:    state_d = S_W1;
      S_W1:    state_d = S_RD;
      S_RD:    state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          instr_q <= instr_i;
          base_q  <= base_value_i;
          sum_q   <= base_value_i + offset_in;
          st0_q   <= store_first_i;
          st1_q   <= store_second_i;
          mode_q  <= mode_in;
          wide_q  <= wide_in;
          load_q  <= instr_i[lsp_pkg::IR_LOAD_BIT];
        end
      end
      S_REL: begin
        rel_q <= ((mode_q == lsp_pkg::MODE_POST) ? base_q : sum_q) - mem_base_q;
      end
      S_CHECK: begin
        if (mode_q == lsp_pkg::MODE_NONE) begin
          status_q <= lsp_pkg::ST_UNSUP;
        end else if (rel_q > (wide_q ? Limit64 : Limit32)) begin
          status_q <= lsp_pkg::ST_RANGE;
        end else begin
          status_q <= lsp_pkg::ST_DONE;
        end
      end
      S_W0:    rd_off_q <= rel_q[lsp_pkg::LANE_BITS-1:0];
      S_W1: begin
        rd_off_q <= addr1[lsp_pkg::LANE_BITS-1:0];
        ld0_q    <= merged;
      end
      S_RD:    ld1_q <= merged;
      S_DONE:  ;
      default: ;
    endcase
  end

  // lane request for the word being moved this cycle
  always_comb begin
    lane_req.en   = (state_q == S_W0) || (state_q == S_W1);
    lane_req.we   = ~load_q;
    lane_req.wide = wide_q;
    lane_addr     = (state_q == S_W1) ? addr1 : rel_q[AW-1:0];
    lane_wdata    = (state_q == S_W1) ? st1_q : st0_q;
  end

  for (genvar g = 0; g < lsp_pkg::LANES; g++) begin : g_lane
    lsp_lane #(
      .MEM_BYTES (MEM_BYTES),
      .LANE      (g)
    ) u_lane (
      .clk_i   (clk_i),
      .req_i   (lane_req),
      .addr_i  (lane_addr),
      .wdata_i (lane_wdata),
      .rdata_o (lane_rdata[g])
    );
  end

  assign merge_ctl.wide = wide_q;
  assign merge_ctl.off  = rd_off_q;

  lsp_merge u_merge (
    .lane_data_i (lane_rdata),
    .ctl_i       (merge_ctl),
    .word_o      (merged)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ld0_q <= (load_q && status_q == lsp_pkg::ST_DONE) ? ld0_q : '0;
      out_ld1_q <= (load_q && status_q == lsp_pkg::ST_DONE) ? ld1_q : '0;
      out_lv_q  <= load_q && (status_q == lsp_pkg::ST_DONE);
      out_bw_q  <= (status_q == lsp_pkg::ST_DONE) && (mode_q != lsp_pkg::MODE_OFFSET);
      out_nb_q  <= ((status_q == lsp_pkg::ST_DONE) && (mode_q != lsp_pkg::MODE_OFFSET))
                 ? sum_q : base_q;
      out_rt_q  <= instr_q[lsp_pkg::IR_RT_LSB +: 5];
      out_rt2_q <= instr_q[lsp_pkg::IR_RT2_LSB +: 5];
      out_rn_q  <= instr_q[lsp_pkg::IR_RN_LSB +: 5];
      out_st_q  <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign load_first_o   = out_ld0_q;
  assign load_second_o  = out_ld1_q;
  assign loads_valid_o  = out_lv_q;
  assign first_reg_o    = out_rt_q;
  assign second_reg_o   = out_rt2_q;
  assign base_reg_o     = out_rn_q;
  assign new_base_o     = out_nb_q;
  assign base_written_o = out_bw_q;
  assign status_o       = out_st_q;

  // lanes are written only by stores that passed the range check
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_req.en && lane_req.we |-> status_q == lsp_pkg::ST_DONE)
    else $error("lane write for an item that failed its check");

  // an accepted item always starts with the relocation step
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_REL)
    else $error("accepted item did not enter relocation");

  // a failed item reports no register write-back
  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != lsp_pkg::ST_DONE |->
      !loads_valid_o && !base_written_o && load_first_o == '0 && load_second_o == '0)
    else $error("failed item reports a write-back");

  // loaded words only come with a successful status
  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loads_valid_o |-> status_o == lsp_pkg::ST_DONE)
    else $error("loads flagged valid on a failed item");

  // no result is loaded while the previous one is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_st_q) && $stable(out_nb_q))
    else $error("stalled result overwritten");

endmodule

[verif/load_store_pair_unit_test.sv]
// ----------------------------------------------------------------------------
// load_store_pair_unit_test: self-checking bench for the load/store pair unit
// Drives load-pair and store-pair items through the input channel, runs each
// one through a local model of the unit and its byte memory, and compares
// every result item field by field. Both channels idle and stall in random
// bursts. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module load_store_pair_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_BYTES    = lsp_pkg::MEM_BYTES_DEFAULT;
  localparam int unsigned DRAIN_CYCLES = 8;     // worst item latency plus margin
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no item moving

  // expected contents of one result item
  typedef struct {
    logic [63:0]      load_first;
    logic [63:0]      load_second;
    logic             loads_valid;
    logic [4:0]       first_reg;
    logic [4:0]       second_reg;
    logic [4:0]       base_reg;
    logic [63:0]      new_base;
    logic             base_written;
    lsp_pkg::status_e status;
  } pair_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [63:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [31:0] instr_i        = '0;
  logic [63:0] base_value_i   = '0;
  logic [63:0] store_first_i  = '0;
  logic [63:0] store_second_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [63:0] load_first_o;
  logic [63:0] load_second_o;
  logic        loads_valid_o;
  logic [4:0]  first_reg_o;
  logic [4:0]  second_reg_o;
  logic [4:0]  base_reg_o;
  logic [63:0] new_base_o;
  logic        base_written_o;
  logic [1:0]  status_o;

  // local copy of the unit's state
  logic [7:0]   shadow_mem   [MEM_BYTES];
  bit           byte_written [MEM_BYTES];
  logic [63:0]  mem_base_copy = '0;

  pair_result_t pending_results [$];
  int unsigned  fail_count      = 0;
  int unsigned  src_idle_pct    = 0;
  int unsigned  sink_idle_pct   = 0;
  int unsigned  sink_stall_left = 0;
  int unsigned  quiet_cycles    = 0;

  load_store_pair_unit #(
    .MEM_BYTES(MEM_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .instr_i       (instr_i),
    .base_value_i  (base_value_i),
    .store_first_i (store_first_i),
    .store_second_i(store_second_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .load_first_o  (load_first_o),
    .load_second_o (load_second_o),
    .loads_valid_o (loads_valid_o),
    .first_reg_o   (first_reg_o),
    .second_reg_o  (second_reg_o),
    .base_reg_o    (base_reg_o),
    .new_base_o    (new_base_o),
    .base_written_o(base_written_o),
    .status_o      (status_o)
  );

  always #5 clk_i = ~clk_i;

  // sign-extended imm7 scaled by the word size
  function automatic logic [63:0] scaled_offset(input logic [6:0] imm, input logic wide);
    logic [63:0] simm;
    simm = {{57{imm[6]}}, imm};
    return wide ? (simm << 3) : (simm << 2);
  endfunction

  function automatic bit span_written(input logic [63:0] rel, input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (!byte_written[rel + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // executes one pair instruction on the local memory copy
  function automatic pair_result_t execute_pair(input logic [31:0] ir,
                                                input logic [63:0] base,
                                                input logic [63:0] first_val,
                                                input logic [63:0] second_val);
    pair_result_t   r;
    lsp_pkg::mode_e mode;
    logic           wide;
    logic [63:0]    offset;
    logic [63:0]    rel;
    int unsigned    wbytes;
    mode   = lsp_pkg::mode_e'(ir[lsp_pkg::IR_MODE_LSB +: 2]);
    wide   = (ir[lsp_pkg::IR_OPC_LSB +: 2] != 2'b00);
    wbytes = wide ? 8 : 4;
    offset = scaled_offset(ir[lsp_pkg::IR_IMM_LSB +: 7], wide);
    r.load_first   = '0;
    r.load_second  = '0;
    r.loads_valid  = 1'b0;
    r.first_reg    = ir[lsp_pkg::IR_RT_LSB +: 5];
    r.second_reg   = ir[lsp_pkg::IR_RT2_LSB +: 5];
    r.base_reg     = ir[lsp_pkg::IR_RN_LSB +: 5];
    r.new_base     = base;
    r.base_written = 1'b0;
    r.status       = lsp_pkg::ST_DONE;
    if (mode == lsp_pkg::MODE_NONE) begin
      r.status = lsp_pkg::ST_UNSUP;
    end else begin
      rel = ((mode == lsp_pkg::MODE_POST) ? base : base + offset) - mem_base_copy;
      if (rel > 64'(MEM_BYTES - 2 * wbytes)) begin
        r.status = lsp_pkg::ST_RANGE;
      end else begin
        // big-endian words, second right after the first
        for (int unsigned i = 0; i < wbytes; i++) begin
          if (ir[lsp_pkg::IR_LOAD_BIT]) begin
            r.load_first  = (r.load_first << 8) | 64'(shadow_mem[rel + i]);
            r.load_second = (r.load_second << 8) | 64'(shadow_mem[rel + wbytes + i]);
          end else begin
            shadow_mem[rel + i]            = 8'(first_val >> (8 * (wbytes - 1 - i)));
            shadow_mem[rel + wbytes + i]   = 8'(second_val >> (8 * (wbytes - 1 - i)));
            byte_written[rel + i]          = 1'b1;
            byte_written[rel + wbytes + i] = 1'b1;
          end
        end
        r.loads_valid = ir[lsp_pkg::IR_LOAD_BIT];
        if (mode != lsp_pkg::MODE_OFFSET) begin
          r.new_base     = base + offset;
          r.base_written = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // sends one item, optionally after an idle burst; valid stays high afterwards
  task automatic send_item(input logic [31:0] ir, input logic [63:0] base,
                           input logic [63:0] first_val, input logic [63:0] second_val);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    instr_i        <= ir;
    base_value_i   <= base;
    store_first_i  <= first_val;
    store_second_i <= second_val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(execute_pair(ir, base, first_val, second_val));
  endtask

  // builds the instruction and picks the base so the access hits byte rel
  task automatic send_pair(input logic [1:0] opc, input lsp_pkg::mode_e mode,
                           input logic is_load,
                           input logic [6:0] imm, input logic [63:0] rel,
                           input logic [14:0] reg_bits,
                           input logic [63:0] first_val, input logic [63:0] second_val);
    logic [31:0] ir;
    logic [63:0] base;
    logic [4:0]  spare;
    spare = 5'($urandom);
    ir    = {opc, spare, mode, is_load, imm, reg_bits};
    base  = mem_base_copy + rel -
            ((mode == lsp_pkg::MODE_POST) ? 64'd0 : scaled_offset(imm, opc != 2'b00));
    send_item(ir, base, first_val, second_val);
  endtask

  // sender stops and waits until every expected result has come
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_memory_base(input logic [63:0] value);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    mem_base_copy = value;
  endtask

  // one random item: mostly legal loads and stores, some noise
  task automatic send_random_item();
    int unsigned    kind;
    int unsigned    span;
    int unsigned    tries;
    logic [1:0]     opc;
    logic [6:0]     imm;
    logic [63:0]    rel;
    logic           is_load;
    lsp_pkg::mode_e mode;
    kind    = $urandom_range(0, 99);
    opc     = $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(1, 3));
    span    = (opc == 2'd0) ? 8 : 16;
    imm     = 7'($urandom);
    mode    = lsp_pkg::mode_e'($urandom_range(1, 3));
    is_load = 1'($urandom);
    if (kind < 8) begin
      mode = lsp_pkg::MODE_NONE;
      rel  = {$urandom, $urandom};
    end else if (kind < 20) begin
      // access partly or wholly outside the memory
      case ($urandom_range(0, 3))
        0:       rel = 64'(MEM_BYTES - span + $urandom_range(1, span - 1));
        1:       rel = 64'(MEM_BYTES + $urandom_range(0, 4096));
        2:       rel = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 600));
        default: rel = {32'($urandom_range(1, 32'hffff_ffff)), $urandom};
      endcase
    end else begin
      is_load = (kind >= 58);
      rel     = 64'($urandom_range(0, MEM_BYTES - span));
      if (is_load) begin
        // only read bytes that were written; fall back to a store
        tries = 0;
        while (tries < 16 && !span_written(rel, span)) begin
          rel   = 64'($urandom_range(0, MEM_BYTES - span));
          tries = tries + 1;
        end
        if (!span_written(rel, span)) is_load = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        rel = $urandom_range(0, 1) ? 64'd0 : 64'(MEM_BYTES - span);
      end
    end
    send_pair(opc, mode, is_load, imm, rel, 15'($urandom),
              {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // every mode and size, field extremes, range edges, misaligned access
  task automatic test_directed_pairs();
    set_memory_base(64'd0);
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    send_pair(2'd1, lsp_pkg::MODE_PRE, 1'b0, 7'h01, 64'd0, 15'h0000, '1,
              64'h0123_4567_89ab_cdef);
    send_pair(2'd1, lsp_pkg::MODE_OFFSET, 1'b1, 7'h7f, 64'd0, 15'h7fff, '0, '0);
    send_pair(2'd0, lsp_pkg::MODE_POST, 1'b1, 7'h40, 64'd4, 15'h1234, '1, '1);
    // top edge of memory, upper halves of store data must be dropped
    send_pair(2'd0, lsp_pkg::MODE_POST, 1'b0, 7'h3f, 64'(MEM_BYTES - 8), 15'h2b5a,
              64'hffff_ffff_0000_0001, 64'hdead_beef_8000_0000);
    send_pair(2'd0, lsp_pkg::MODE_OFFSET, 1'b1, 7'h3f, 64'(MEM_BYTES - 8), 15'h54a5,
              '0, '0);
    send_pair(2'd3, lsp_pkg::MODE_OFFSET, 1'b0, 7'h15, 64'(MEM_BYTES - 16), 15'h7c1f,
              '0, '1);
    send_pair(2'd2, lsp_pkg::MODE_PRE, 1'b1, 7'h40, 64'(MEM_BYTES - 16), 15'h03e0,
              '0, '0);
    send_pair(2'd1, lsp_pkg::MODE_POST, 1'b1, 7'h00, 64'd0, 15'h5555, '0, '0);
    // unsupported mode, load and store
    send_pair(2'd1, lsp_pkg::MODE_NONE, 1'b1, 7'h22, {$urandom, $urandom}, 15'h2aaa,
              '1, '1);
    send_pair(2'd0, lsp_pkg::MODE_NONE, 1'b0, 7'h5d, 64'd0, 15'h0421, '1, '1);
    // just outside or far outside the memory
    send_pair(2'd1, lsp_pkg::MODE_POST, 1'b1, 7'h08, 64'(MEM_BYTES - 15), 15'h1111,
              '0, '0);
    send_pair(2'd0, lsp_pkg::MODE_PRE, 1'b0, 7'h7e, 64'(MEM_BYTES - 7), 15'h6666,
              '1, '1);
    send_pair(2'd0, lsp_pkg::MODE_OFFSET, 1'b1, 7'h01, '1, 15'h7777, '0, '0);
    send_pair(2'd3, lsp_pkg::MODE_POST, 1'b0, 7'h11, 64'h8000_0000_0000_0000, 15'h0001,
              '1, '0);
    send_pair(2'd1, lsp_pkg::MODE_PRE, 1'b1, 7'h3c, 64'(MEM_BYTES), 15'h4000, '0, '0);
    // misaligned store, then an overlapping load
    send_pair(2'd0, lsp_pkg::MODE_PRE, 1'b0, 7'h7f, 64'd1, 15'h3210,
              64'h0000_0000_a5c3_0f81, 64'h1234_5678_7e01_ff00);
    send_pair(2'd0, lsp_pkg::MODE_POST, 1'b1, 7'h2a, 64'd3, 15'h0123, '0, '0);
  endtask

  // memory placed where addresses wrap around zero
  task automatic test_base_wraparound();
    set_memory_base('1);
    send_pair(2'd2, lsp_pkg::MODE_PRE, 1'b0, 7'h7f, 64'd0, 15'h7fff,
              {$urandom, $urandom}, {$urandom, $urandom});
    send_pair(2'd3, lsp_pkg::MODE_OFFSET, 1'b1, 7'h40, 64'd0, 15'h0000, '0, '0);
    set_memory_base(64'hffff_ffff_ffff_f000);
    send_pair(2'd0, lsp_pkg::MODE_POST, 1'b0, 7'h40, 64'(MEM_BYTES - 8), 15'h1357,
              {$urandom, $urandom}, {$urandom, $urandom});
    send_pair(2'd1, lsp_pkg::MODE_PRE, 1'b1, 7'h3f, 64'(MEM_BYTES - 16), 15'h2468,
              '0, '0);
    send_pair(2'd1, lsp_pkg::MODE_POST, 1'b1, 7'h05, 64'(MEM_BYTES), 15'h7531, '0, '0);
  endtask

  task automatic test_random_traffic(input logic [63:0] mem_base, input int unsigned count,
                                     input int unsigned src_pct, input int unsigned sink_pct);
    set_memory_base(mem_base);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_random_item();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // result channel back-pressure in random bursts
  always @(posedge clk_i) begin
    if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      out_ready_i     <= 1'b0;
      sink_stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    pair_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("load_first", exp_res.load_first, load_first_o);
        check_field("load_second", exp_res.load_second, load_second_o);
        check_field("loads_valid", 64'(exp_res.loads_valid), 64'(loads_valid_o));
        check_field("first_reg", 64'(exp_res.first_reg), 64'(first_reg_o));
        check_field("second_reg", 64'(exp_res.second_reg), 64'(second_reg_o));
        check_field("base_reg", 64'(exp_res.base_reg), 64'(base_reg_o));
        check_field("new_base", exp_res.new_base, new_base_o);
        check_field("base_written", 64'(exp_res.base_written), 64'(base_written_o));
        check_field("status", 64'(exp_res.status), 64'(status_o));
      end
    end
  end

  // watchdog: ends the run when no item moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("load_store_pair_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_pairs();
    test_base_wraparound();
    test_random_traffic({$urandom, $urandom}, 200, 20, 20);
    test_random_traffic(64'h0000_0000_0000_1000, 200, 40, 5);
    test_random_traffic({$urandom, $urandom}, 200, 5, 40);
    // last stretch runs at full rate on both sides
    test_random_traffic(64'h7fff_ffff_ffff_f800, 220, 0, 0);
    wait_results_drained();
    if (fail_count == 0) begin
      $display("load_store_pair_unit regression: pass");
    end else begin
      $display("load_store_pair_unit regression: fail");
    end
    $finish;
  end

endmodule
